// ===== design/cwh_pkg.sv =====
// Shared types, codes and constants of the column waveform histogram.
package cwh_pkg;

   localparam int OP_BITS       = 2;
   localparam int LEVEL_BITS    = 8;
   localparam int POS_BITS      = 13;
   localparam int PLANE_BITS    = 2;
   localparam int READ_BIN_BITS = 7;
   localparam int OUT_BITS      = 20;
   localparam int CSR_BITS      = 14;
   localparam int CSR_ADDR_BITS = 2;

   localparam int LEVELS       = 256;
   localparam int COLOR_PLANES = 3;

   localparam int DEF_COLUMNS    = 128;
   localparam int DEF_COUNT_BITS = 20;
   localparam int DEF_MAX_WIDTH  = 8192;

   typedef logic [OP_BITS-1:0]       op_type;
   typedef logic [LEVEL_BITS-1:0]    level_type;
   typedef logic [POS_BITS-1:0]      pos_type;
   typedef logic [PLANE_BITS-1:0]    plane_type;
   typedef logic [READ_BIN_BITS-1:0] read_bin_type;
   typedef logic [OUT_BITS-1:0]      count_out_type;
   typedef logic [CSR_BITS-1:0]      csr_data_type;
   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;

   localparam op_type OP_ACCUMULATE = 2'd0;
   localparam op_type OP_CLEAR      = 2'd1;
   localparam op_type OP_READ       = 2'd2;

   localparam plane_type PLANE_RED   = 2'd0;
   localparam plane_type PLANE_GREEN = 2'd1;
   localparam plane_type PLANE_BLUE  = 2'd2;
   localparam plane_type PLANE_LUMA  = 2'd3;

   localparam csr_addr_type CSR_FRAME_WIDTH = 2'd0;
   localparam csr_addr_type CSR_SAMPLE_STEP = 2'd1;

   localparam csr_data_type FRAME_WIDTH_RESET = 14'd1920;
   localparam csr_data_type SAMPLE_STEP_RESET = 14'd1;

   // Rec.601 integer luma: (299 R + 587 G + 114 B) / 1000
   localparam int LUMA_SUM_BITS = 18;
   localparam logic [LUMA_SUM_BITS-1:0] LUMA_WEIGHT_R = 18'd299;
   localparam logic [LUMA_SUM_BITS-1:0] LUMA_WEIGHT_G = 18'd587;
   localparam logic [LUMA_SUM_BITS-1:0] LUMA_WEIGHT_B = 18'd114;
   localparam csr_data_type LUMA_DIVISOR = 14'd1000;

endpackage

// ===== design/cwh_if.sv =====
// Request, response and register-write channel interfaces.
interface cwh_req_if;
   import cwh_pkg::*;
   logic         valid;
   logic         ready;
   op_type       operation;
   level_type    red;
   level_type    green;
   level_type    blue;
   pos_type      pixel_column;
   pos_type      pixel_row;
   plane_type    read_plane;
   read_bin_type read_bin;
   level_type    read_level;

   modport source (output valid, operation, red, green, blue, pixel_column, pixel_row,
                   read_plane, read_bin, read_level, input ready);
   modport sink (input valid, operation, red, green, blue, pixel_column, pixel_row,
                 read_plane, read_bin, read_level, output ready);
endinterface

interface cwh_rsp_if;
   import cwh_pkg::*;
   logic          valid;
   logic          ready;
   count_out_type bin_count;

   modport source (output valid, bin_count, input ready);
   modport sink (input valid, bin_count, output ready);
endinterface

interface cwh_csr_if;
   import cwh_pkg::*;
   logic         valid;
   logic         ready;
   csr_addr_type addr;
   csr_data_type wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

// ===== design/column_waveform_histogram_unit.sv =====
// Column waveform histogram: top level with counter memories and control.
//
//   channel    dir  handshake    payload
//   req_port   in   valid/ready  operation, red, green, blue, pixel_column, pixel_row,
//                                read_plane, read_bin, read_level
//   rsp_port   out  valid/ready  bin_count (one per read request)
//   csr_port   in   valid/ready  addr (0 frame_width, 1 sample_step), wdata
//
// A counted pixel is loaded, divided, fetched and bumped in red, green and blue;
// DIV_STEPS is 13 + clog2(COLUMNS) steps of the restoring divider lanes (step, bin);
// a pixel off the sampling grid stops after the fetch, one outside the frame after
// the load. Luma is a multiply. A read holds in its result state while the response
// register is full; a clear is the sweep of the color memory, one entry a cycle.
// After reset the same sweep runs before the first request is taken.
module column_waveform_histogram_unit #(
   parameter int COLUMNS    = cwh_pkg::DEF_COLUMNS,
   parameter int COUNT_BITS = cwh_pkg::DEF_COUNT_BITS,
   parameter int MAX_WIDTH  = cwh_pkg::DEF_MAX_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   cwh_req_if.sink    req_port,
   cwh_rsp_if.source  rsp_port,
   cwh_csr_if.sink    csr_port
);
   import cwh_pkg::*;

   localparam int BIN_BITS        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int CELLS           = COLUMNS * LEVELS;
   localparam int COLOR_CELLS     = COLOR_PLANES * CELLS;
   localparam int CELL_BITS       = $clog2(CELLS);
   localparam int COLOR_ADDR_BITS = $clog2(COLOR_CELLS);
   localparam int PROD_BITS       = POS_BITS + $clog2(COLUMNS);
   localparam int DIV_STEPS       = PROD_BITS;
   localparam int STEP_BITS       = $clog2(DIV_STEPS);
   localparam int LANES           = 3;
   localparam int LANE_COL        = 0;
   localparam int LANE_ROW        = 1;
   localparam int LANE_BIN        = 2;
   localparam int PLANES          = COLOR_PLANES + 1;

   // ceil(2^26 / 1000): exact floor division for every luma sum up to 255 * 1000
   localparam int LUMA_RECIP_BITS = 17;
   localparam int LUMA_SHIFT      = 26;
   localparam int LUMA_PROD_BITS  = LUMA_SUM_BITS + LUMA_RECIP_BITS;
   localparam logic [LUMA_RECIP_BITS-1:0] LUMA_RECIP = 17'd67109;

   localparam logic [CSR_BITS:0]      WIDTH_CAP = (CSR_BITS + 1)'(MAX_WIDTH);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LOAD   = 4'd2;
   localparam logic [3:0] ST_DIV    = 4'd3;
   localparam logic [3:0] ST_FETCH  = 4'd4;
   localparam logic [3:0] ST_BUMP_R = 4'd5;
   localparam logic [3:0] ST_BUMP_G = 4'd6;
   localparam logic [3:0] ST_BUMP_B = 4'd7;
   localparam logic [3:0] ST_RESULT = 4'd8;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   logic [3:0]                 state_ff, state_in;
   logic [COLOR_ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [STEP_BITS-1:0]       div_cnt_ff, div_cnt_in;
   csr_data_type               frame_width_ff, sample_step_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   count_out_type              rsp_count_ff, rsp_count_in;

   // captured request
   op_type       op_ff;
   level_type    red_ff, green_ff, blue_ff;
   pos_type      col_ff, row_ff;
   plane_type    plane_ff;
   read_bin_type rbin_ff;
   level_type    rlevel_ff;

   logic [DIV_STEPS-1:0] lane_num_ff [LANES];
   logic [DIV_STEPS-1:0] lane_num_in [LANES];
   csr_data_type         lane_rem_ff [LANES];
   csr_data_type         lane_rem_in [LANES];
   csr_data_type         lane_div    [LANES];
   logic [DIV_STEPS-1:0] lane_load   [LANES];
   logic [DIV_STEPS-1:0] num_step    [LANES];
   csr_data_type         rem_step    [LANES];
   logic [CSR_BITS:0]    trial       [LANES];
   logic                 fits        [LANES];

   logic                       req_fire;
   csr_data_type               width_eff, step_eff;
   logic                       in_frame, sampled, rbin_ok;
   logic [LUMA_SUM_BITS-1:0]   luma_sum_in, luma_sum_ff;
   logic [LUMA_PROD_BITS-1:0]  luma_prod;
   level_type                  luma_level_in, luma_level_ff;
   logic [PROD_BITS-1:0]       col_prod;
   logic [BIN_BITS-1:0]        pix_bin;
   level_type                  pix_level [PLANES];
   logic [CELL_BITS-1:0]       pix_cell  [PLANES];
   logic [COLOR_ADDR_BITS-1:0] pix_caddr [COLOR_PLANES];
   logic [CELL_BITS-1:0]       rd_cell;
   logic [COLOR_ADDR_BITS-1:0] rd_caddr;

   logic                       color_we, color_re;
   logic [COLOR_ADDR_BITS-1:0] color_waddr, color_raddr;
   logic [COUNT_BITS-1:0]      color_wdata, color_rdata_ff;
   logic                       luma_we, luma_re;
   logic [CELL_BITS-1:0]       luma_addr;
   logic [COUNT_BITS-1:0]      luma_wdata, luma_rdata_ff;

   logic [COUNT_BITS-1:0] color_mem [COLOR_CELLS];
   logic [COUNT_BITS-1:0] luma_mem  [CELLS];

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_port.valid & req_port.ready;
   assign csr_port.ready = 1'b1;
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.bin_count = rsp_count_ff;

   // ---------------- datapath ----------------
   always_comb begin
      width_eff = ({1'b0, frame_width_ff} > WIDTH_CAP) ? CSR_BITS'(WIDTH_CAP) : frame_width_ff;
      step_eff  = (sample_step_ff == '0) ? CSR_BITS'(1) : sample_step_ff;
      in_frame  = CSR_BITS'(col_ff) < width_eff;
      // luma sum registers after capture, the scaled quotient in the cycle after
      luma_sum_in   = LUMA_SUM_BITS'(red_ff) * LUMA_WEIGHT_R
                    + LUMA_SUM_BITS'(green_ff) * LUMA_WEIGHT_G
                    + LUMA_SUM_BITS'(blue_ff) * LUMA_WEIGHT_B;
      luma_prod     = LUMA_PROD_BITS'(luma_sum_ff) * LUMA_PROD_BITS'(LUMA_RECIP);
      luma_level_in = luma_prod[LUMA_SHIFT +: LEVEL_BITS];
      col_prod  = PROD_BITS'(col_ff) * PROD_BITS'(COLUMNS);

      lane_div[LANE_COL]  = step_eff;
      lane_div[LANE_ROW]  = step_eff;
      lane_div[LANE_BIN]  = width_eff;
      lane_load[LANE_COL]  = DIV_STEPS'(col_ff);
      lane_load[LANE_ROW]  = DIV_STEPS'(row_ff);
      lane_load[LANE_BIN]  = DIV_STEPS'(col_prod);

      // one restoring step per lane; quotient bits shift in behind the dividend
      for (int i = 0; i < LANES; i++) begin
         trial[i]    = {lane_rem_ff[i], lane_num_ff[i][DIV_STEPS-1]};
         fits[i]     = trial[i] >= {1'b0, lane_div[i]};
         rem_step[i] = fits[i] ? CSR_BITS'(trial[i] - {1'b0, lane_div[i]})
                               : CSR_BITS'(trial[i]);
         num_step[i] = {lane_num_ff[i][DIV_STEPS-2:0], fits[i]};
      end

      sampled = (lane_rem_ff[LANE_COL] == '0) && (lane_rem_ff[LANE_ROW] == '0);
      pix_bin = lane_num_ff[LANE_BIN][BIN_BITS-1:0];
      pix_level[PLANE_RED]   = red_ff;
      pix_level[PLANE_GREEN] = green_ff;
      pix_level[PLANE_BLUE]  = blue_ff;
      pix_level[PLANE_LUMA]  = luma_level_ff;
      for (int i = 0; i < PLANES; i++) begin
         pix_cell[i] = (CELL_BITS'(pix_bin) << LEVEL_BITS) | CELL_BITS'(pix_level[i]);
      end
      for (int i = 0; i < COLOR_PLANES; i++) begin
         pix_caddr[i] = COLOR_ADDR_BITS'(i * CELLS) + COLOR_ADDR_BITS'(pix_cell[i]);
      end

      rbin_ok  = 32'(rbin_ff) < 32'(COLUMNS);
      rd_cell  = (CELL_BITS'(rbin_ff) << LEVEL_BITS) | CELL_BITS'(rlevel_ff);
      rd_caddr = COLOR_ADDR_BITS'(plane_ff) * COLOR_ADDR_BITS'(CELLS)
               + COLOR_ADDR_BITS'(rd_cell);
   end

   // ---------------- control ----------------
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_port.ready;
      rsp_count_in = rsp_count_ff;
      for (int i = 0; i < LANES; i++) begin
         lane_num_in[i] = lane_num_ff[i];
         lane_rem_in[i] = lane_rem_ff[i];
      end

      color_we    = 1'b0;
      color_re    = 1'b0;
      color_waddr = pix_caddr[PLANE_RED];
      color_raddr = pix_caddr[PLANE_RED];
      color_wdata = bump(color_rdata_ff);
      luma_we     = 1'b0;
      luma_re     = 1'b0;
      luma_addr   = pix_cell[PLANE_LUMA];
      luma_wdata  = bump(luma_rdata_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            color_we    = 1'b1;
            color_waddr = clr_addr_ff;
            color_wdata = '0;
            luma_we     = 32'(clr_addr_ff) < CELLS;
            luma_addr   = CELL_BITS'(clr_addr_ff);
            luma_wdata  = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == COLOR_ADDR_BITS'(COLOR_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               clr_addr_in = '0;
               state_in    = (req_port.operation == OP_CLEAR) ? ST_CLEAR : ST_LOAD;
            end
         end
         ST_LOAD: begin
            unique case (op_ff)
               OP_ACCUMULATE: begin
                  if (in_frame) begin
                     div_cnt_in = '0;
                     for (int i = 0; i < LANES; i++) begin
                        lane_num_in[i] = lane_load[i];
                        lane_rem_in[i] = '0;
                     end
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               OP_READ: begin
                  color_re    = (plane_ff != PLANE_LUMA);
                  color_raddr = rd_caddr;
                  luma_re     = 1'b1;
                  luma_addr   = rd_cell;
                  state_in    = ST_RESULT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            for (int i = 0; i < LANES; i++) begin
               lane_num_in[i] = num_step[i];
               lane_rem_in[i] = rem_step[i];
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (sampled) begin
               color_re = 1'b1;
               luma_re  = 1'b1;
               state_in = ST_BUMP_R;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BUMP_R: begin
            // red count is back: write it, fetch green, write luma
            color_we    = 1'b1;
            color_waddr = pix_caddr[PLANE_RED];
            color_re    = 1'b1;
            color_raddr = pix_caddr[PLANE_GREEN];
            luma_we     = 1'b1;
            state_in    = ST_BUMP_G;
         end
         ST_BUMP_G: begin
            color_we    = 1'b1;
            color_waddr = pix_caddr[PLANE_GREEN];
            color_re    = 1'b1;
            color_raddr = pix_caddr[PLANE_BLUE];
            state_in    = ST_BUMP_B;
         end
         ST_BUMP_B: begin
            color_we    = 1'b1;
            color_waddr = pix_caddr[PLANE_BLUE];
            state_in    = ST_IDLE;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               if (!rbin_ok) begin
                  rsp_count_in = '0;
               end else if (plane_ff == PLANE_LUMA) begin
                  rsp_count_in = OUT_BITS'(luma_rdata_ff);
               end else begin
                  rsp_count_in = OUT_BITS'(color_rdata_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         frame_width_ff <= FRAME_WIDTH_RESET;
         sample_step_ff <= SAMPLE_STEP_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_port.valid) begin
            unique case (csr_port.addr)
               CSR_FRAME_WIDTH: frame_width_ff <= csr_port.wdata;
               CSR_SAMPLE_STEP: sample_step_ff <= csr_port.wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff  <= rsp_count_in;
      luma_sum_ff   <= luma_sum_in;
      luma_level_ff <= luma_level_in;
      for (int i = 0; i < LANES; i++) begin
         lane_num_ff[i] <= lane_num_in[i];
         lane_rem_ff[i] <= lane_rem_in[i];
      end
      if (req_fire) begin
         op_ff     <= req_port.operation;
         red_ff    <= req_port.red;
         green_ff  <= req_port.green;
         blue_ff   <= req_port.blue;
         col_ff    <= req_port.pixel_column;
         row_ff    <= req_port.pixel_row;
         plane_ff  <= req_port.read_plane;
         rbin_ff   <= req_port.read_bin;
         rlevel_ff <= req_port.read_level;
      end
   end

   // ---------------- counter memories ----------------
   // color: one write and one read port, planes stacked red, green, blue
   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[color_waddr] <= color_wdata;
      end
      if (color_re) begin
         color_rdata_ff <= color_mem[color_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (luma_we) begin
         luma_mem[luma_addr] <= luma_wdata;
      end else if (luma_re) begin
         luma_rdata_ff <= luma_mem[luma_addr];
      end
   end

`ifndef ASSERT_OFF
   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_port.operation == OP_CLEAR) |=> (state_ff == ST_CLEAR))
      else $error("clear request did not start the sweep");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESULT))
      else $error("response raised outside a read");

   a_bump_after_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUMP_R) |-> ($past(state_ff) == ST_FETCH))
      else $error("count write without a preceding fetch");
`endif

endmodule
